[rtl/core/point_rotate_three_axis_macros.svh]
// Assertion macros used by the point rotator top level.
`ifndef POINT_ROTATE_THREE_AXIS_MACROS_SVH
`define POINT_ROTATE_THREE_AXIS_MACROS_SVH

// Same-cycle implication.
`define PRT_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRT_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/prt_pkg.sv]
// Shared constants and types of the three-axis point rotator.
package prt_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int TRIG_BITS_DEF = 16;

  localparam int ANGLE_BITS = 16;
  localparam int IDX_BITS = 14;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_Z = 2'd2;

  // pi/2 in unsigned Q60
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  typedef struct packed {
    logic busy;
    logic done;
  } trig_stat_t;

endpackage

[rtl/core/prt_ifs.sv]
// Stream and configuration channel interfaces of the point rotator.
interface prt_in_if #(parameter int COORD_BITS = prt_pkg::COORD_BITS_DEF);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;
  logic signed [COORD_BITS-1:0] in_red;
  logic signed [COORD_BITS-1:0] in_green;
  logic signed [COORD_BITS-1:0] in_blue;

  modport source (output valid, in_x, in_y, in_z, in_red, in_green, in_blue, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_red, in_green, in_blue, output ready);
endinterface

interface prt_out_if #(parameter int COORD_BITS = prt_pkg::COORD_BITS_DEF);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic signed [COORD_BITS-1:0] out_red;
  logic signed [COORD_BITS-1:0] out_green;
  logic signed [COORD_BITS-1:0] out_blue;

  modport source (output valid, out_x, out_y, out_z, out_red, out_green, out_blue,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_red, out_green, out_blue,
                output ready);
endinterface

interface prt_cfg_if;
  logic valid;
  logic ready;
  logic [prt_pkg::CFG_INDEX_BITS-1:0] index;
  logic [prt_pkg::ANGLE_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/prt_trig.sv]
// Sequential sine/cosine unit: quarter-wave Taylor series in Q60 per angle.
module prt_trig #(
  parameter int TRIG_BITS = prt_pkg::TRIG_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [prt_pkg::ANGLE_BITS-1:0] angle,
  output prt_pkg::trig_stat_t stat,
  output logic signed [TRIG_BITS-1:0] sin_val,
  output logic signed [TRIG_BITS-1:0] cos_val
);
  import prt_pkg::*;

  localparam int FRAC = TRIG_BITS - 1;
  localparam logic [63:0] TOP = (64'd1 << FRAC) - 64'd1;
  localparam logic [63:0] HALF = 64'd1 << (59 - FRAC);
  localparam logic [IDX_BITS:0] QUARTER = (IDX_BITS + 1)'(1) << IDX_BITS;
  localparam int TERMS = 15;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_X     = 3'd1;
  localparam logic [2:0] ST_X2    = 3'd2;
  localparam logic [2:0] ST_TMUL  = 3'd3;
  localparam logic [2:0] ST_TDIV  = 3'd4;
  localparam logic [2:0] ST_ROUND = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [1:0] QD_I   = 2'd0;
  localparam logic [1:0] QD_II  = 2'd1;
  localparam logic [1:0] QD_III = 2'd2;

  logic [2:0] state;
  logic [2:0] mcnt;
  logic [3:0] dcnt;
  logic [3:0] k;
  logic second;
  logic [1:0] quad;
  logic [IDX_BITS-1:0] idx;
  logic [63:0] mul_a, mul_b;
  logic [63:0] pp;
  logic [1:0] pp_code;
  logic [127:0] acc;
  logic [63:0] x2, term, sum, dq;
  logic [9:0] rem;
  logic [FRAC-1:0] si;

  logic in_mul;
  logic [31:0] a_part, b_part;
  logic [127:0] pp_shifted;
  logic [63:0] mres;
  logic [4:0] k2;
  logic [9:0] dvs;
  logic [63:0] dq_next;
  logic [9:0] rem_next;
  logic [10:0] trial;
  logic [63:0] vsum, vsh, vsel;
  logic [FRAC-1:0] v;
  logic [IDX_BITS:0] j2;
  logic signed [TRIG_BITS-1:0] psi, psc;

  assign in_mul = (state == ST_X) || (state == ST_X2) || (state == ST_TMUL);
  assign a_part = mcnt[1] ? mul_a[63:32] : mul_a[31:0];
  assign b_part = mcnt[0] ? mul_b[63:32] : mul_b[31:0];
  assign mres = acc[123:60];

  always_comb begin
    case (pp_code)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd3:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {32'd0, pp, 32'd0};
    endcase
  end

  // divisor (2k)(2k+1)
  assign k2 = {k, 1'b0};
  assign dvs = 10'(k2) * 10'(k2 + 5'd1);

  // four restoring quotient bits per cycle
  always_comb begin
    dq_next = dq;
    rem_next = rem;
    trial = '0;
    for (int b = 0; b < 4; b++) begin
      trial = {rem_next, dq_next[63]};
      dq_next = dq_next << 1;
      if (trial >= {1'b0, dvs}) begin
        rem_next = 10'(trial - {1'b0, dvs});
        dq_next[0] = 1'b1;
      end else begin
        rem_next = trial[9:0];
      end
    end
  end

  assign vsum = sum + HALF;
  assign vsh = vsum >> (60 - FRAC);
  assign vsel = (vsh > TOP) ? TOP : vsh;
  assign v = vsel[FRAC-1:0];
  assign j2 = QUARTER - {1'b0, idx};
  assign psi = signed'({1'b0, si});
  assign psc = signed'({1'b0, v});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mcnt <= '0;
    end else begin
      if (in_mul) begin
        if (mcnt < 3'd4) begin
          pp <= a_part * b_part;
          pp_code <= mcnt[1:0];
        end
        if (mcnt == 3'd0) begin
          acc <= '0;
        end else if (mcnt <= 3'd4) begin
          acc <= acc + pp_shifted;
        end
        mcnt <= (mcnt == 3'd5) ? 3'd0 : mcnt + 3'd1;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            quad <= angle[ANGLE_BITS-1:IDX_BITS];
            idx <= angle[IDX_BITS-1:0];
            second <= 1'b0;
            mul_a <= HALF_PI_Q60;
            mul_b <= 64'({1'b0, angle[IDX_BITS-1:0]}) << 46;
            mcnt <= '0;
            state <= ST_X;
          end
        end
        ST_X: begin
          if (mcnt == 3'd5) begin
            term <= mres;
            sum <= mres;
            mul_a <= mres;
            mul_b <= mres;
            state <= ST_X2;
          end
        end
        ST_X2: begin
          if (mcnt == 3'd5) begin
            x2 <= mres;
            mul_a <= term;
            mul_b <= mres;
            k <= 4'd1;
            state <= ST_TMUL;
          end
        end
        ST_TMUL: begin
          if (mcnt == 3'd5) begin
            dq <= mres;
            rem <= '0;
            dcnt <= '0;
            state <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          dq <= dq_next;
          rem <= rem_next;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            term <= dq_next;
            sum <= k[0] ? sum - dq_next : sum + dq_next;
            if (k == 4'(TERMS)) begin
              state <= ST_ROUND;
            end else begin
              k <= k + 4'd1;
              mul_a <= dq_next;
              mul_b <= x2;
              mcnt <= '0;
              state <= ST_TMUL;
            end
          end
        end
        ST_ROUND: begin
          if (!second) begin
            si <= v;
            second <= 1'b1;
            mul_a <= HALF_PI_Q60;
            mul_b <= 64'(j2) << 46;
            mcnt <= '0;
            state <= ST_X;
          end else begin
            case (quad)
              QD_I: begin
                sin_val <= psi;
                cos_val <= psc;
              end
              QD_II: begin
                sin_val <= psc;
                cos_val <= -psi;
              end
              QD_III: begin
                sin_val <= -psi;
                cos_val <= -psc;
              end
              default: begin
                sin_val <= -psc;
                cos_val <= psi;
              end
            endcase
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_DONE);

endmodule

[rtl/core/prt_rot.sv]
// One plane rotation: registered products, then rounded sum and difference.
module prt_rot #(
  parameter int W_IN = prt_pkg::COORD_BITS_DEF,
  parameter int W_OUT = prt_pkg::COORD_BITS_DEF + 1,
  parameter int TRIG_BITS = prt_pkg::TRIG_BITS_DEF
) (
  input  logic clk,
  input  logic en_mul,
  input  logic en_sum,
  input  logic signed [W_IN-1:0] a,
  input  logic signed [W_IN-1:0] b,
  input  logic signed [TRIG_BITS-1:0] c,
  input  logic signed [TRIG_BITS-1:0] s,
  output logic signed [W_OUT-1:0] p,
  output logic signed [W_OUT-1:0] q
);
  localparam int FRAC = TRIG_BITS - 1;
  localparam int PW = W_IN + TRIG_BITS;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RHALF = SW'(64'd1 << (FRAC - 1));

  logic signed [PW-1:0] ca, sb, sa, cb;
  logic signed [SW-1:0] p_sum, q_sum;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      ca <= PW'(c) * PW'(a);
      sb <= PW'(s) * PW'(b);
      sa <= PW'(s) * PW'(a);
      cb <= PW'(c) * PW'(b);
    end
  end

  // p = c*a - s*b, q = s*a + c*b, round half up
  assign p_sum = SW'(ca) - SW'(sb) + RHALF;
  assign q_sum = SW'(sa) + SW'(cb) + RHALF;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      p <= W_OUT'(p_sum >>> FRAC);
      q <= W_OUT'(q_sum >>> FRAC);
    end
  end

endmodule

[rtl/core/point_rotate_three_axis.sv]
// Three-axis point rotator top level: angle registers, trig unit, 7-stage pipeline.
//
// Channels: sample takes one point (x, y, z and three colour channels) per
// transfer; rotated delivers exactly one result per point, in order. cfg
// writes angle registers 0 (x), 1 (y), 2 (z); other indexes are dropped.
// Points are rotated about x, then y, then z; colours pass through.
//
// Seven register stages. Throughput: one point per cycle while rotated
// takes results, the trig unit is idle and cfg.valid is low; each stage
// holds a valid bit and moves when the stage after it is empty or moving,
// so bubbles close up and the input keeps taking points while a result
// waits at the output register. When rotated stalls, the pipe fills and
// sample.ready drops; nothing is lost or repeated.
//
// A write to an angle register starts the sequential sine/cosine unit, busy
// through two 15-term series, each term a 64x64 multiply built from four
// 32x32 products plus a restoring divide. sample.ready and cfg.ready stay
// low meanwhile.
// Reset: synchronous; clears the pipe and sets all angles to zero (sine 0,
// cosine at its largest code), ready again the cycle after reset.
`include "point_rotate_three_axis_macros.svh"

module point_rotate_three_axis #(
  parameter int COORD_BITS = prt_pkg::COORD_BITS_DEF,
  parameter int TRIG_BITS = prt_pkg::TRIG_BITS_DEF
) (
  input logic clk,
  input logic rst,
  prt_in_if.sink sample,
  prt_out_if.source rotated,
  prt_cfg_if.sink cfg
);
  import prt_pkg::*;

  localparam int C = COORD_BITS;
  localparam int W1 = COORD_BITS + 1;
  localparam int W2 = COORD_BITS + 2;
  localparam logic signed [TRIG_BITS-1:0] COEF_MAX = {1'b0, {(TRIG_BITS - 1){1'b1}}};
  localparam logic signed [C-1:0] OUT_MAX = {1'b0, {(C - 1){1'b1}}};
  localparam logic signed [C-1:0] OUT_MIN = {1'b1, {(C - 1){1'b0}}};

  function automatic logic signed [C-1:0] sat(input logic signed [W2-1:0] val);
    logic [2:0] top3;
    top3 = val[W2-1:C-1];
    if (top3 == 3'b000 || top3 == 3'b111) begin
      sat = val[C-1:0];
    end else begin
      sat = val[W2-1] ? OUT_MIN : OUT_MAX;
    end
  endfunction

  // coefficients and trig unit
  trig_stat_t tstat;
  logic signed [TRIG_BITS-1:0] t_sin, t_cos;
  logic signed [TRIG_BITS-1:0] sin_c [3];
  logic signed [TRIG_BITS-1:0] cos_c [3];
  logic [CFG_INDEX_BITS-1:0] axis;
  logic axis_ok;
  logic trig_start;

  assign cfg.ready = !tstat.busy;
  assign axis_ok = (cfg.index == CFG_ANGLE_X) || (cfg.index == CFG_ANGLE_Y) ||
                   (cfg.index == CFG_ANGLE_Z);
  assign trig_start = cfg.valid && cfg.ready && axis_ok;

  prt_trig #(.TRIG_BITS(TRIG_BITS)) u_trig (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .angle   (cfg.data),
    .stat    (tstat),
    .sin_val (t_sin),
    .cos_val (t_cos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= CFG_ANGLE_X;
      for (int a = 0; a < 3; a++) begin
        sin_c[a] <= '0;
        cos_c[a] <= COEF_MAX;
      end
    end else begin
      if (trig_start) begin
        axis <= cfg.index;
      end
      if (tstat.done) begin
        sin_c[axis] <= t_sin;
        cos_c[axis] <= t_cos;
      end
    end
  end

  // pipeline control
  logic [7:1] v;
  logic [7:1] en;
  logic in_take;

  always_comb begin
    en[7] = !v[7] || rotated.ready;
    for (int s = 6; s >= 1; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign sample.ready = en[1] && !tstat.busy && !cfg.valid;
  assign in_take = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= sample.valid && !tstat.busy && !cfg.valid;
      end
      for (int s = 2; s <= 7; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // datapath
  logic signed [W1-1:0] y2, z2, zo_4, x2_4;
  logic signed [W2-1:0] xo_6, yo_6;
  logic signed [C-1:0] x_s1, x_s2;
  logic signed [W1-1:0] y2_s3, y2_s4, zo_s5, zo_s6;
  logic [3*C-1:0] col [7];
  logic signed [C-1:0] ox, oy, oz;

  prt_rot #(.W_IN(C), .W_OUT(W1), .TRIG_BITS(TRIG_BITS)) u_rot_x (
    .clk    (clk),
    .en_mul (en[1]),
    .en_sum (en[2]),
    .a      (sample.in_y),
    .b      (sample.in_z),
    .c      (cos_c[0]),
    .s      (sin_c[0]),
    .p      (y2),
    .q      (z2)
  );

  prt_rot #(.W_IN(W1), .W_OUT(W1), .TRIG_BITS(TRIG_BITS)) u_rot_y (
    .clk    (clk),
    .en_mul (en[3]),
    .en_sum (en[4]),
    .a      (z2),
    .b      (W1'(x_s2)),
    .c      (cos_c[1]),
    .s      (sin_c[1]),
    .p      (zo_4),
    .q      (x2_4)
  );

  prt_rot #(.W_IN(W1), .W_OUT(W2), .TRIG_BITS(TRIG_BITS)) u_rot_z (
    .clk    (clk),
    .en_mul (en[5]),
    .en_sum (en[6]),
    .a      (x2_4),
    .b      (y2_s4),
    .c      (cos_c[2]),
    .s      (sin_c[2]),
    .p      (xo_6),
    .q      (yo_6)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_s1 <= sample.in_x;
      col[0] <= {sample.in_red, sample.in_green, sample.in_blue};
    end
    for (int s = 1; s <= 6; s++) begin
      if (en[s+1]) begin
        col[s] <= col[s-1];
      end
    end
    if (en[2]) x_s2 <= x_s1;
    if (en[3]) y2_s3 <= y2;
    if (en[4]) y2_s4 <= y2_s3;
    if (en[5]) zo_s5 <= zo_4;
    if (en[6]) zo_s6 <= zo_s5;
    if (en[7]) begin
      ox <= sat(xo_6);
      oy <= sat(yo_6);
      oz <= sat(W2'(zo_s6));
    end
  end

  assign rotated.valid = v[7];
  assign rotated.out_x = ox;
  assign rotated.out_y = oy;
  assign rotated.out_z = oz;
  assign rotated.out_red = col[6][3*C-1:2*C];
  assign rotated.out_green = col[6][2*C-1:C];
  assign rotated.out_blue = col[6][C-1:0];

  `PRT_ASSERT_IMP(a_no_take_busy, clk, rst, in_take, !tstat.busy, "point taken while busy")
  `PRT_ASSERT_NXT(a_cfg_starts, clk, rst, trig_start, tstat.busy, "trig unit did not start")
  `PRT_ASSERT_NXT(a_done_ends, clk, rst, tstat.done, !tstat.busy, "trig unit busy after done")

endmodule

[verif/point_rotate_three_axis_checker.sv]
// Checker for the three-axis point rotator: predicts each rotated point and compares.
`timescale 1ns / 100ps

module point_rotate_three_axis_checker (
  input logic clk,
  input logic rst,
  prt_in_if sample,
  prt_out_if rotated,
  prt_cfg_if cfg,
  output int errors,
  output int pending
);
  import prt_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int FRAC = TRIG_BITS_DEF - 1;
  localparam int QUARTER = 1 << IDX_BITS;
  localparam longint COEF_TOP = (longint'(1) << FRAC) - 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] red;
    logic signed [CW-1:0] green;
    logic signed [CW-1:0] blue;
  } point_t;

  point_t expected_q[$];
  longint sin_k[3];
  longint cos_k[3];

  // bits [123:60] of the 128-bit product, unsigned Q60
  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic longint quarter_wave(int unsigned idx);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] rounded;
    ang = (HALF_PI_Q60 >> 14) * idx + (((HALF_PI_Q60 & 64'h3FFF) * idx) >> 14);
    ang_sq = q60_mul(ang, ang);
    term = ang;
    acc = ang;
    for (int k = 1; k <= 15; k++) begin
      term = q60_mul(term, ang_sq) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    rounded = (acc + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
    return (rounded > 64'(COEF_TOP)) ? COEF_TOP : longint'(rounded);
  endfunction

  task automatic load_angle(input int axis, input logic [ANGLE_BITS-1:0] angle);
    longint s_lo;
    longint s_hi;
    s_lo = quarter_wave(angle[IDX_BITS-1:0]);
    s_hi = quarter_wave(QUARTER - angle[IDX_BITS-1:0]);
    case (angle[ANGLE_BITS-1:IDX_BITS])
      2'd0: begin sin_k[axis] = s_lo;  cos_k[axis] = s_hi;  end
      2'd1: begin sin_k[axis] = s_hi;  cos_k[axis] = -s_lo; end
      2'd2: begin sin_k[axis] = -s_lo; cos_k[axis] = -s_hi; end
      default: begin sin_k[axis] = -s_hi; cos_k[axis] = s_lo; end
    endcase
  endtask

  function automatic longint stage_round(longint v);
    return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [CW-1:0] clamp(longint v);
    longint top;
    top = (longint'(1) << (CW - 1)) - 1;
    if (v > top) v = top;
    if (v < -top - 1) v = -top - 1;
    return v[CW-1:0];
  endfunction

  // x, then y, then z
  function automatic point_t rotate_point(point_t p);
    longint px, py, pz, y1, z1, x2;
    point_t r;
    px = p.x;
    py = p.y;
    pz = p.z;
    y1 = stage_round(cos_k[0] * py - sin_k[0] * pz);
    z1 = stage_round(sin_k[0] * py + cos_k[0] * pz);
    x2 = stage_round(cos_k[1] * px + sin_k[1] * z1);
    r.z = clamp(stage_round(cos_k[1] * z1 - sin_k[1] * px));
    r.x = clamp(stage_round(cos_k[2] * x2 - sin_k[2] * y1));
    r.y = clamp(stage_round(sin_k[2] * x2 + cos_k[2] * y1));
    r.red = p.red;
    r.green = p.green;
    r.blue = p.blue;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [CW-1:0] want, got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    point_t p;
    point_t want;
    if (rst) begin
      expected_q.delete();
      for (int a = 0; a < 3; a++) load_angle(a, '0);
      pending <= 0;
    end else begin
      if (sample.valid && sample.ready) begin
        p.x = sample.in_x;
        p.y = sample.in_y;
        p.z = sample.in_z;
        p.red = sample.in_red;
        p.green = sample.in_green;
        p.blue = sample.in_blue;
        expected_q.push_back(rotate_point(p));
      end
      if (rotated.valid && rotated.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual x %0d y %0d z %0d",
                   $time, rotated.out_x, rotated.out_y, rotated.out_z);
        end else begin
          want = expected_q.pop_front();
          check_field("x", want.x, rotated.out_x);
          check_field("y", want.y, rotated.out_y);
          check_field("z", want.z, rotated.out_z);
          check_field("red", want.red, rotated.out_red);
          check_field("green", want.green, rotated.out_green);
          check_field("blue", want.blue, rotated.out_blue);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_ANGLE_X, CFG_ANGLE_Y, CFG_ANGLE_Z: load_angle(int'(cfg.index), cfg.data);
          default: ;
        endcase
      end
      pending <= expected_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// Top of the point rotator testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module testbench;
  import prt_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE = CW'(1) << 20;
  localparam logic [CW-1:0] NEG_ONE = -ONE;
  localparam int PHASES = 12;
  localparam int PHASE_POINTS = 125;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;
  logic out_ready = 1'b0;
  bit calm_out = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int fail_count;
  int outstanding;

  prt_in_if point_in ();
  prt_out_if point_out ();
  prt_cfg_if angle_cfg ();

  assign point_out.ready = out_ready;

  point_rotate_three_axis u_dut (
    .clk(clk),
    .rst(rst),
    .sample(point_in),
    .rotated(point_out),
    .cfg(angle_cfg)
  );

  point_rotate_three_axis_checker u_checker (
    .clk(clk),
    .rst(rst),
    .sample(point_in),
    .rotated(point_out),
    .cfg(angle_cfg),
    .errors(fail_count),
    .pending(outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // output backpressure in bursts
  always @(posedge clk) begin
    if (rst || calm_out) begin
      out_ready <= !rst;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (point_in.valid && point_in.ready) || (point_out.valid && point_out.ready) ||
        (angle_cfg.valid && angle_cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return CMAX;
      1: return CMIN;
      2: return {{(CW-12){r[31]}}, r[11:0]};
      default: return r[CW-1:0];
    endcase
  endfunction

  function automatic logic [ANGLE_BITS-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {2'($urandom_range(0, 3)), 14'd0};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_point(input logic [CW-1:0] x, y, z, r, g, b);
    point_in.valid <= 1'b1;
    point_in.in_x <= x;
    point_in.in_y <= y;
    point_in.in_z <= z;
    point_in.in_red <= r;
    point_in.in_green <= g;
    point_in.in_blue <= b;
    do @(posedge clk); while (!point_in.ready);
  endtask

  task automatic rest_input(input int n);
    point_in.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_idle();
    point_in.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_angle(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [ANGLE_BITS-1:0] value);
    angle_cfg.valid <= 1'b1;
    angle_cfg.index <= idx;
    angle_cfg.data <= value;
    do @(posedge clk); while (!angle_cfg.ready);
  endtask

  task automatic load_angles(input logic [ANGLE_BITS-1:0] ax, ay, az);
    wait_idle();
    write_angle(CFG_ANGLE_X, ax);
    write_angle(CFG_ANGLE_Y, ay);
    write_angle(CFG_ANGLE_Z, az);
    angle_cfg.valid <= 1'b0;
  endtask

  task automatic send_corners();
    send_point(CMAX, CMAX, CMAX, CMAX, CMIN, '0);
    send_point(CMIN, CMIN, CMIN, CMIN, CMAX, '1);
    send_point(CMAX, CMIN, '0, ONE, NEG_ONE, CMAX);
    send_point(ONE, NEG_ONE, ONE, '0, '1, CMIN);
  endtask

  initial begin
    bit steady;
    rst <= 1'b1;
    point_in.valid <= 1'b0;
    point_in.in_x <= '0;
    point_in.in_y <= '0;
    point_in.in_z <= '0;
    point_in.in_red <= '0;
    point_in.in_green <= '0;
    point_in.in_blue <= '0;
    angle_cfg.valid <= 1'b0;
    angle_cfg.index <= CFG_ANGLE_X;
    angle_cfg.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset angles: unit cosine saturated, zero sine
    send_corners();
    send_point('0, '0, '0, '0, '0, '0);

    // write to an unused index must leave the angles alone
    wait_idle();
    write_angle(CFG_UNUSED, '1);
    angle_cfg.valid <= 1'b0;
    send_corners();

    // quadrant boundaries, top angle, and 45 degrees driving saturation
    load_angles(16'h4000, 16'h8000, 16'hC000);
    send_corners();
    load_angles('1, '1, '1);
    send_corners();
    load_angles(16'h2000, 16'h2000, 16'h2000);
    send_corners();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_angles(rand_angle(), rand_angle(), rand_angle());
      steady = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      calm_out <= (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        if (!steady && $urandom_range(0, 3) == 0) rest_input($urandom_range(1, 6));
        send_point(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
      end
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
